// ===== rtl/script_token_scanner_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the token scanner modules
// Each macro expects signals named clk and arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_SCANNER_TOP_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define STSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg
// Types and constants shared by the script token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package stsc_pkg;

	// Fixed field widths of one result item.
	localparam int TOKEN_LEN_W = 11;
	localparam int LINE_W      = 24;
	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_TOKEN_LEN = 1024;
	localparam int DEF_QUEUE_DEPTH   = 4;

	// Character codes the scanner looks for.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// One result item.
	typedef struct packed {
		logic                   char_valid;
		logic [7:0]             token_char;
		logic                   token_end;
		logic [TOKEN_LEN_W-1:0] token_length;
		logic                   was_quoted;
		logic                   truncated;
		logic                   empty_line_break;
		logic                   end_of_data;
		logic [LINE_W-1:0]      line_number;
		logic                   last_of_run;
	} res_t;

	// All results caused by one input byte: one or two items.
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} bundle_t;

endpackage

`default_nettype wire

// ===== rtl/stsc_if.sv =====
// ----------------------------------------------------------------------------
// Scanner channel interfaces
// Text byte input, configuration write and result output channels.
// ----------------------------------------------------------------------------
`default_nettype none

// Text input: one byte per item.
interface stsc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

// Configuration write: the single line-break control register.
interface stsc_cfg_if;
	logic valid;
	logic ready;
	logic allow_line_breaks;

	modport source (output valid, output allow_line_breaks, input ready);
	modport sink (input valid, input allow_line_breaks, output ready);
endinterface

// Result output: one token character and/or token event per item.
interface stsc_res_if import stsc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   char_valid;
	logic [7:0]             token_char;
	logic                   token_end;
	logic [TOKEN_LEN_W-1:0] token_length;
	logic                   was_quoted;
	logic                   truncated;
	logic                   empty_line_break;
	logic                   end_of_data;
	logic [LINE_W-1:0]      line_number;
	logic                   last_of_run;

	modport source (
		output valid, input ready,
		output char_valid, output token_char, output token_end, output token_length,
		output was_quoted, output truncated, output empty_line_break,
		output end_of_data, output line_number, output last_of_run
	);
	modport sink (
		input valid, output ready,
		input char_valid, input token_char, input token_end, input token_length,
		input was_quoted, input truncated, input empty_line_break,
		input end_of_data, input line_number, input last_of_run
	);
endinterface

`default_nettype wire

// ===== rtl/stsc_front.sv =====
// ----------------------------------------------------------------------------
// stsc_front
// Accepts text bytes, runs the scanner state machine and builds the
// result bundle for each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stsc_front import stsc_pkg::*; #(
	parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stsc_byte_if.sink   text,
	input  wire logic   allow_lb,
	input  wire logic   q_full,
	output logic        push,
	output bundle_t     push_data
);

	localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN_LEN);
	localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);
	localparam logic [LEN_W-1:0] LEN_TWO   = LEN_W'(2);

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SLASH,
		PH_LINEC,
		PH_BLOCK,
		PH_BLOCKSTAR,
		PH_BARE,
		PH_QUOTE
	} phase_t;

	phase_t            phase_q, phase_n;
	logic              qd_q, qd_n;
	logic [LEN_W-1:0]  len_q, len_n;
	logic              ovf_q, ovf_n;
	logic [LINE_W-1:0] line_q, line_n, line_out;
	logic              gap_q, gap_n;

	logic        accept;
	logic [7:0]  b;
	logic        b_ws, b_lf, b_cr, b_quote;
	logic        gap_step, line_inc, emit_b, end_tok;
	logic [1:0]  n;
	res_t        res [2];

	assign accept = text.valid && text.ready;
	assign text.ready = !q_full;
	assign b = text.byte_in;
	assign b_ws = (b <= CH_SPACE);
	assign b_lf = (b == CH_LF);
	assign b_cr = (b == CH_CR);
	assign b_quote = (b == (qd_q ? CH_DQUOTE : CH_SQUOTE));

	// Next state and result items for the byte on the input.
	always_comb begin
		phase_n  = phase_q;
		qd_n     = qd_q;
		len_n    = len_q;
		ovf_n    = ovf_q;
		gap_n    = gap_q;
		gap_step = 1'b0;
		line_inc = 1'b0;
		emit_b   = 1'b0;
		end_tok  = 1'b0;
		n        = 2'd0;
		res[0]   = '0;
		res[1]   = '0;

		if (b == CH_NUL) begin
			// End of buffer: close any open token and reset the parser.
			res[0].end_of_data = 1'b1;
			n = 2'd1;
			if (phase_q == PH_SLASH) begin
				res[0].char_valid   = 1'b1;
				res[0].token_char   = CH_SLASH;
				res[0].token_end    = 1'b1;
				res[0].token_length = TOKEN_LEN_W'(1);
			end else if (phase_q == PH_BARE || phase_q == PH_QUOTE) begin
				res[0].token_end    = 1'b1;
				res[0].token_length = TOKEN_LEN_W'(len_q);
				res[0].was_quoted   = (phase_q == PH_QUOTE);
				res[0].truncated    = ovf_q;
			end
			phase_n = PH_SKIP;
			qd_n    = 1'b0;
			len_n   = '0;
			ovf_n   = 1'b0;
			gap_n   = 1'b0;
		end else begin
			case (phase_q)
				PH_SKIP: begin
					if (b_ws) begin
						gap_step = 1'b1;
					end else if (b == CH_SLASH) begin
						phase_n = PH_SLASH;
						len_n   = '0;
						ovf_n   = 1'b0;
						gap_n   = 1'b0;
					end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
						phase_n = PH_QUOTE;
						qd_n    = (b == CH_DQUOTE);
						len_n   = '0;
						ovf_n   = 1'b0;
						gap_n   = 1'b0;
					end else begin
						phase_n = PH_BARE;
						len_n   = LEN_ONE;
						ovf_n   = 1'b0;
						gap_n   = 1'b0;
						res[0].char_valid = 1'b1;
						res[0].token_char = b;
						n = 2'd1;
					end
				end
				PH_SLASH: begin
					len_n = '0;
					ovf_n = 1'b0;
					if (b == CH_SLASH) begin
						phase_n = PH_LINEC;
					end else if (b == CH_STAR) begin
						phase_n = PH_BLOCK;
					end else begin
						// A lone slash starts a bare token, or forms a one-character token when whitespace follows.
						res[0].char_valid = 1'b1;
						res[0].token_char = CH_SLASH;
						if (!b_ws) begin
							phase_n = PH_BARE;
							len_n   = LEN_TWO;
							res[1].char_valid = 1'b1;
							res[1].token_char = b;
							n = 2'd2;
						end else begin
							res[0].token_end    = 1'b1;
							res[0].token_length = TOKEN_LEN_W'(1);
							phase_n  = PH_SKIP;
							len_n    = LEN_ONE;
							n        = 2'd1;
							gap_step = 1'b1;
						end
					end
				end
				PH_LINEC: begin
					if (b_lf) begin
						phase_n  = PH_SKIP;
						gap_step = 1'b1;
					end
				end
				PH_BLOCK, PH_BLOCKSTAR: begin
					if (phase_q == PH_BLOCKSTAR && b == CH_SLASH) begin
						phase_n = PH_SKIP;
					end else begin
						line_inc = b_lf;
						phase_n  = (b == CH_STAR) ? PH_BLOCKSTAR : PH_BLOCK;
					end
				end
				PH_BARE: begin
					if (!b_ws) begin
						emit_b = 1'b1;
					end else begin
						end_tok  = 1'b1;
						phase_n  = PH_SKIP;
						gap_step = 1'b1;
					end
				end
				PH_QUOTE: begin
					line_inc = b_lf;
					if (b_quote || ((b_cr || b_lf) && !allow_lb)) begin
						end_tok = 1'b1;
						phase_n = PH_SKIP;
					end else begin
						emit_b = 1'b1;
					end
				end
				default: begin
					phase_n = PH_SKIP;
				end
			endcase

			// Token end for a bare or quoted token.
			if (end_tok) begin
				res[0].token_end    = 1'b1;
				res[0].token_length = TOKEN_LEN_W'(len_q);
				res[0].was_quoted   = (phase_q == PH_QUOTE);
				res[0].truncated    = ovf_q;
				n = 2'd1;
			end

			// Token character, dropped once the token is full.
			if (emit_b) begin
				if (len_q >= LEN_LIMIT) begin
					ovf_n = 1'b1;
				end else begin
					len_n = LEN_W'(len_q + LEN_ONE);
					res[0].char_valid = 1'b1;
					res[0].token_char = b;
					n = 2'd1;
				end
			end

			// Whitespace between tokens: count lines and, without allow_lb, report one gap marker.
			if (gap_step && b_lf) begin
				line_inc = 1'b1;
				if (!allow_lb && !gap_q) begin
					gap_n = 1'b1;
					res[n[0]].token_end        = 1'b1;
					res[n[0]].empty_line_break = 1'b1;
					n = 2'(n + 2'd1);
				end
			end
		end

		line_n = (line_inc && line_q != LINE_MAX) ? LINE_W'(line_q + 1'b1) : line_q;
		if (b == CH_NUL) begin
			line_out = line_q;
			line_n   = LINE_W'(1);
		end else begin
			line_out = line_n;
		end

		res[0].line_number = line_out;
		res[1].line_number = line_out;
		res[0].last_of_run = (n == 2'd1);
		res[1].last_of_run = (n == 2'd2);
	end

	assign push = accept && (n != 2'd0);
	assign push_data = '{r0: res[0], r1: res[1], two: (n == 2'd2)};

	// Scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			qd_q    <= 1'b0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			line_q  <= LINE_W'(1);
			gap_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			qd_q    <= qd_n;
			len_q   <= len_n;
			ovf_q   <= ovf_n;
			line_q  <= line_n;
			gap_q   <= gap_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stsc_queue.sv =====
// ----------------------------------------------------------------------------
// stsc_queue
// Short queue of result bundles between the scanner and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

`include "script_token_scanner_top_macros.svh"

module stsc_queue import stsc_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t push_data,
	output logic         full,
	input  wire logic    pop,
	output bundle_t      head,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	bundle_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	`STSC_ASSERT_IMP(a_no_push_full, push, !full, "bundle pushed into a full queue")
	`STSC_ASSERT_IMP(a_no_pop_empty, pop, !empty, "bundle popped from an empty queue")
	`STSC_ASSERT_NEXT(a_count_up, push && !pop, count_q == CNT_W'($past(count_q) + 1'b1),
		"fill count did not follow a push")

endmodule

`default_nettype wire

// ===== rtl/stsc_back.sv =====
// ----------------------------------------------------------------------------
// stsc_back
// Unpacks queued bundles and delivers their result items one by one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "script_token_scanner_top_macros.svh"

module stsc_back import stsc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bundle_t head,
	input  wire logic    empty,
	output logic         pop,
	stsc_res_if.source   tokens
);

	logic sub_q;
	logic accept;
	res_t sel;

	assign sel    = sub_q ? head.r1 : head.r0;
	assign accept = tokens.valid && tokens.ready;
	assign pop    = accept && (sub_q || !head.two);

	// Output channel.
	assign tokens.valid            = !empty;
	assign tokens.char_valid       = sel.char_valid;
	assign tokens.token_char       = sel.token_char;
	assign tokens.token_end        = sel.token_end;
	assign tokens.token_length     = sel.token_length;
	assign tokens.was_quoted       = sel.was_quoted;
	assign tokens.truncated        = sel.truncated;
	assign tokens.empty_line_break = sel.empty_line_break;
	assign tokens.end_of_data      = sel.end_of_data;
	assign tokens.line_number      = sel.line_number;
	assign tokens.last_of_run      = sel.last_of_run;

	// Selects the second item of a pair after the first one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (accept) begin
			sub_q <= !pop;
		end
	end

	`STSC_ASSERT_NEXT(a_pair_second, accept && !sub_q && head.two, sub_q && tokens.valid,
		"second item of a pair went missing")
	`STSC_ASSERT_IMP(a_pop_whole, pop, sub_q || !head.two,
		"pair popped before its second item was taken")

endmodule

`default_nettype wire

// ===== rtl/script_token_scanner_top.sv =====
// ----------------------------------------------------------------------------
// script_token_scanner_top
// Streaming script tokenizer with line and block comments.
// ----------------------------------------------------------------------------
//   Channel     Role     Payload
//   text        input    byte_in, one text byte per item
//   config_wr   input    allow_line_breaks register write
//   tokens      output   token character, token end and status fields
//
// One text byte is accepted per cycle; the scanner stalls only when the
// result queue is full, and its state machine decides each byte
// combinationally. A byte gives zero, one or two result items; a pair
// leaves the output as two items, and the result queue absorbs it. The
// output side drains the queue independently. Reset clears the parser,
// the queue and the register. Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module script_token_scanner_top import stsc_pkg::*; #(
	parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
	parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stsc_byte_if.sink  text,
	stsc_cfg_if.sink   config_wr,
	stsc_res_if.source tokens
);

	logic    allow_q;
	logic    push, q_full, pop, q_empty;
	bundle_t push_data, head;

	// Line-break control register.
	assign config_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_q <= 1'b0;
		end else if (config_wr.valid && config_wr.ready) begin
			allow_q <= config_wr.allow_line_breaks;
		end
	end

	stsc_front #(
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.allow_lb  (allow_q),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	stsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	stsc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

`default_nettype wire
